>>> rtl/core/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
// Used by fit_policy_block_allocator_core; depends on nothing.
package fpba_pkg;

    // Default sizing of the free-size table
    localparam int NUM_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths
    localparam int IDX_W  = 5;
    localparam int REQ_W  = 16;
    localparam int BCNT_W = 6;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 6;

    // Placement policy codes (anything else acts as first fit)
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FIT_MODE    = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] block_index;
        logic [REQ_W-1:0] size_value;
        logic             last_request;
    } t_req_item;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] chosen_block;
        logic             batch_end;
    } t_res_item;

endpackage

>>> rtl/core/fpba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fit_policy_block_allocator_core.sv
// Fit-policy block allocator: load items set a block's free size, request items
// scan the table under first/best/worst fit. Load items give no result.
// Request: with L = min(block_count, NUM_BLOCKS) the scan reads entries 0 to L-1,
// one RAM read per entry plus an update step that registers the result; the next
// item is taken once the core is back in idle, later while the result waits.
// Reset (synchronous, active low) clears config, then a RAM clear of every entry.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req_item  i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_res_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = SIZE_BITS + REQ_W;
    localparam logic [CNT_W+BCNT_W-1:0] NB_EXT  = (CNT_W+BCNT_W)'(NUM_BLOCKS);
    localparam logic [CNT_W+IDX_W-1:0]  NB_IEXT = (CNT_W+IDX_W)'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]        CLR_END = CNT_W'(NUM_BLOCKS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state              r_state;
    logic [MODE_W-1:0]   r_fit_mode;
    logic [BCNT_W-1:0]   r_block_count;
    logic [CNT_W-1:0]    r_clr_addr;
    logic [CNT_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_limit;
    logic                r_pend;
    logic [AW-1:0]       r_pend_idx;
    logic [REQ_W-1:0]    r_size;
    logic                r_last;
    logic                r_found;
    logic [AW-1:0]       r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic                r_out_valid;
    t_res_item           r_out_item;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [SIZE_BITS-1:0] ram_rdata;

    logic                     in_acc;
    logic                     out_free;
    logic                     issue;
    logic                     fits;
    logic                     take;
    logic [CNT_W+BCNT_W-1:0]  bc_ext;
    logic [CNT_W-1:0]         limit;
    logic                     load_ok;
    logic [AW+IDX_W-1:0]      load_addr_ext;
    logic [CMP_W-1:0]         req_ext;
    logic [CMP_W-1:0]         rd_ext;
    logic [CMP_W-1:0]         best_ext;
    logic [CMP_W-1:0]         diff_ext;
    logic [CMP_W-1:0]         load_ext;
    logic [AW+IDX_W-1:0]      pick_ext;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Search limit: block_count clipped to the table depth
    assign bc_ext = {{CNT_W{1'b0}}, r_block_count};
    assign limit  = (bc_ext > NB_EXT) ? NB_EXT[CNT_W-1:0] : bc_ext[CNT_W-1:0];

    // Load address check and extension
    assign load_ok       = ({{CNT_W{1'b0}}, i_in_item.block_index} < NB_IEXT);
    assign load_addr_ext = {{AW{1'b0}}, i_in_item.block_index};
    assign load_ext      = {{SIZE_BITS{1'b0}}, i_in_item.size_value};

    // Candidate evaluation on the entry read last cycle
    assign issue    = (r_state == S_SCAN) && (r_addr < r_limit);
    assign req_ext  = {{SIZE_BITS{1'b0}}, r_size};
    assign rd_ext   = {{REQ_W{1'b0}}, ram_rdata};
    assign best_ext = {{REQ_W{1'b0}}, r_best};
    assign diff_ext = best_ext - req_ext;
    assign fits     = (rd_ext >= req_ext);
    assign take     = r_pend && fits &&
                      (!r_found ||
                       ((r_fit_mode == FIT_BEST) && (ram_rdata < r_best)) ||
                       ((r_fit_mode == FIT_WORST) && (ram_rdata > r_best)));
    assign pick_ext = {{IDX_W{1'b0}}, r_pick};

    // RAM write port: clearing pass, loads, allocation update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr[AW-1:0];
        ram_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_we    = in_acc && (i_in_item.operation == OP_LOAD) && load_ok;
                ram_waddr = load_addr_ext[AW-1:0];
                ram_wdata = load_ext[SIZE_BITS-1:0];
            end
            S_UPDATE: begin
                ram_we    = r_found && out_free;
                ram_waddr = r_pick;
                ram_wdata = diff_ext[SIZE_BITS-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= FIT_FIRST;
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BCNT_W-1:0];
                default:         r_fit_mode    <= r_fit_mode;
            endcase
        end
    end

    // Control sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads this cycle
            if (r_out_valid && i_out_ready && (r_state != S_UPDATE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == CLR_END) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (i_in_item.operation == OP_REQUEST)) begin
                        r_size  <= i_in_item.size_value;
                        r_last  <= i_in_item.last_request;
                        r_limit <= limit;
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle, evaluate the one returned
                    r_pend     <= issue;
                    r_pend_idx <= r_addr[AW-1:0];
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_state <= S_UPDATE;
                    end
                    if (take) begin
                        r_found <= 1'b1;
                        r_pick  <= r_pend_idx;
                        r_best  <= ram_rdata;
                    end
                end
                S_UPDATE: begin
                    if (out_free) begin
                        r_out_valid             <= 1'b1;
                        r_out_item.granted      <= r_found;
                        r_out_item.chosen_block <= r_found ? pick_ext[IDX_W-1:0] : '0;
                        r_out_item.batch_end    <= r_last;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A refused request always reports block zero
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.granted) |-> (r_out_item.chosen_block == '0))
        else $error("ungranted result carries a nonzero block index");

    // The scan counter never runs past the search limit
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_limit))
        else $error("scan address beyond search limit");

    // No RAM write can disturb an entry while a scan is in flight
    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !ram_we)
        else $error("RAM written during scan");

    // A new result only appears at the end of the update step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPDATE))
        else $error("result produced outside update step");

    // Leaving reset always starts the clearing pass
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (r_state == S_CLEAR) && !o_in_ready)
        else $error("items accepted before clearing pass");

endmodule
